/* design/twq_pkg.sv */
// Shared constants, codes and types of the timed wakeup event queue.
`timescale 1ns / 1ps

package twq_pkg;

  localparam int QUEUE_DEPTH   = 32;
  localparam int NUM_CONSUMERS = 64;
  localparam int TIME_W        = 32;
  localparam int CID_W         = 6;
  localparam int CNT_W         = 6;
  localparam int IDX_W         = $clog2(NUM_CONSUMERS);

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CID_W-1:0]  cid_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    OP_SCHED   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_DRAIN   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_WAKE       = 3'd0,
    KIND_DONE       = 3'd1,
    KIND_SCHED      = 3'd2,
    KIND_REDUNDANT  = 3'd3,
    KIND_NOT_FUTURE = 3'd4,
    KIND_FULL       = 3'd5
  } kind_t;

  // one queue slot
  typedef struct packed {
    logic  vld;
    time_t tm;
    cid_t  who;
  } entry_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

/* design/twq_if.sv */
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps

interface twq_in_if import twq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  cid_t       consumer_id;
  time_t      time_value;

  modport source (output valid, output opcode, output consumer_id, output time_value,
                  input ready);
  modport sink (input valid, input opcode, input consumer_id, input time_value,
                output ready);
endinterface

interface twq_out_if import twq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  cid_t       woken_consumer;
  time_t      event_time;
  cnt_t       pending_count;
  logic       last;

  modport source (output valid, output kind, output woken_consumer, output event_time,
                  output pending_count, output last, input ready);
  modport sink (input valid, input kind, input woken_consumer, input event_time,
                input pending_count, input last, output ready);
endinterface

/* design/twq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module twq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/twq_cell.sv */
// One slot of the sorted event chain: holds, shifts in, or takes the new event.
`timescale 1ns / 1ps

module twq_cell import twq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  time_t     new_tm,
  input  cid_t      new_who,
  input  entry_t    prev_ent,
  input  logic      prev_keep,
  input  entry_t    next_ent,
  output entry_t    ent,
  output logic      keep
);

  logic  vld_r, vld_nxt;
  time_t tm_r, tm_nxt;
  cid_t  who_r, who_nxt;

  // slot stays put on insert when it holds an event not later than the new one
  assign keep = vld_r && (tm_r <= new_tm);

  always_comb begin
    vld_nxt = vld_r;
    tm_nxt  = tm_r;
    who_nxt = who_r;
    if (ctl.pop) begin
      vld_nxt = next_ent.vld;
      tm_nxt  = next_ent.tm;
      who_nxt = next_ent.who;
    end else if (ctl.ins && !keep) begin
      if (prev_keep) begin
        vld_nxt = 1'b1;
        tm_nxt  = new_tm;
        who_nxt = new_who;
      end else begin
        vld_nxt = prev_ent.vld;
        tm_nxt  = prev_ent.tm;
        who_nxt = prev_ent.who;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tm_r  <= tm_nxt;
    who_r <= who_nxt;
  end

  assign ent = '{vld: vld_r, tm: tm_r, who: who_r};

endmodule

/* design/timed_wakeup_event_queue.sv */
// Top level: wakeup scheduler with a sorted cell chain and last-wakeup RAM.
//
//   port     dir   words
//   in_ch    sink  opcode, consumer_id, time_value
//   out_ch   src   kind, woken_consumer, event_time, pending_count, last
//
// Schedule: the last-wakeup RAM is read first, then the request is decided and inserted.
// Advance/drain: the request is accepted, then one result word per cycle while the output is
// not stalled (each wakeup is one pop of the chain), ending with the done word.
// Reset: synchronous, empty queue, time one, no consumer has a recorded wakeup.
// A stalled output holds the chain; a new request is taken while the last word waits.
`timescale 1ns / 1ps

module timed_wakeup_event_queue import twq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  twq_in_if.sink    in_ch,
  twq_out_if.source out_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCHED, ST_POP} state_t;

  state_t state_r;
  logic   drain_r;
  cid_t   who_r;
  time_t  tgt_r;
  time_t  cur_r;
  cnt_t   cnt_r;
  logic   lw_vld_r [NUM_CONSUMERS];

  logic   out_valid_r;
  kind_t  out_kind_r;
  cid_t   out_who_r;
  time_t  out_time_r;
  cnt_t   out_pend_r;
  logic   out_last_r;

  logic   accept, out_free, out_load;
  time_t  lw_rd, lw_time;
  logic   sched_ok, due;
  kind_t  sched_kind;
  cell_ctl_t ctl;

  entry_t chain_ent  [QUEUE_DEPTH];
  logic   chain_keep [QUEUE_DEPTH];
  entry_t head;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = out_free && ((state_r == ST_SCHED) || (state_r == ST_POP));
  assign head        = chain_ent[0];

  // read address held on the latched consumer while a schedule waits
  twq_ram #(.WIDTH(TIME_W), .DEPTH(NUM_CONSUMERS)) u_lw_ram (
    .clk     (clk),
    .wr_en   (ctl.ins),
    .wr_addr (who_r[IDX_W-1:0]),
    .wr_data (tgt_r),
    .rd_addr ((state_r == ST_IDLE) ? in_ch.consumer_id[IDX_W-1:0] : who_r[IDX_W-1:0]),
    .rd_data (lw_rd)
  );

  // unwritten entries read as zero, i.e. no wakeup yet
  assign lw_time = lw_vld_r[who_r[IDX_W-1:0]] ? lw_rd : '0;

  always_comb begin
    sched_ok = 1'b0;
    if (lw_time == tgt_r) begin
      sched_kind = KIND_REDUNDANT;
    end else if (!(tgt_r > cur_r)) begin
      sched_kind = KIND_NOT_FUTURE;
    end else if (cnt_r >= CNT_W'(QUEUE_DEPTH)) begin
      sched_kind = KIND_FULL;
    end else begin
      sched_kind = KIND_SCHED;
      sched_ok   = 1'b1;
    end
  end

  assign due     = (cnt_r != '0) && (drain_r || (head.tm <= tgt_r));
  assign ctl.ins = (state_r == ST_SCHED) && out_free && sched_ok;
  assign ctl.pop = (state_r == ST_POP) && out_free && due;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_k;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_k = 1'b1;
    end else begin : g_mid
      assign prev_e = chain_ent[i-1];
      assign prev_k = chain_keep[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = chain_ent[i+1];
    end

    twq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_tm    (tgt_r),
      .new_who   (who_r),
      .prev_ent  (prev_e),
      .prev_keep (prev_k),
      .next_ent  (next_e),
      .ent       (chain_ent[i]),
      .keep      (chain_keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drain_r     <= 1'b0;
      cur_r       <= TIME_W'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CONSUMERS; i++) begin
        lw_vld_r[i] <= 1'b0;
      end
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            who_r <= in_ch.consumer_id;
            tgt_r <= in_ch.time_value;
            unique case (in_ch.opcode)
              OP_SCHED: begin
                state_r <= ST_SCHED;
              end
              OP_ADVANCE: begin
                drain_r <= 1'b0;
                state_r <= ST_POP;
              end
              OP_DRAIN: begin
                drain_r <= 1'b1;
                state_r <= ST_POP;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SCHED: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= sched_kind;
            out_who_r   <= who_r;
            out_time_r  <= tgt_r;
            out_last_r  <= 1'b1;
            if (sched_ok) begin
              cnt_r                     <= cnt_r + 1'b1;
              out_pend_r                <= cnt_r + 1'b1;
              lw_vld_r[who_r[IDX_W-1:0]] <= 1'b1;
            end else begin
              out_pend_r <= cnt_r;
            end
            state_r <= ST_IDLE;
          end
        end
        ST_POP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (due) begin
              out_kind_r <= KIND_WAKE;
              out_who_r  <= head.who;
              out_time_r <= head.tm;
              out_pend_r <= cnt_r - 1'b1;
              out_last_r <= 1'b0;
              cnt_r      <= cnt_r - 1'b1;
              cur_r      <= head.tm;
            end else begin
              out_kind_r <= KIND_DONE;
              out_who_r  <= '0;
              out_time_r <= drain_r ? cur_r : tgt_r;
              out_pend_r <= cnt_r;
              out_last_r <= 1'b1;
              if (!drain_r) begin
                cur_r <= tgt_r;
              end
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.woken_consumer = out_who_r;
  assign out_ch.event_time     = out_time_r;
  assign out_ch.pending_count  = out_pend_r;
  assign out_ch.last           = out_last_r;

endmodule

/* tb/sv/tb_timed_wakeup_event_queue.sv */
// Testbench for the timed wakeup event queue: random and directed requests, scoreboard check.
`timescale 1ns / 1ps

module tb_timed_wakeup_event_queue;
  import twq_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         N_RANDOM    = 260;

  typedef struct {
    kind_t kind;
    cid_t  who;
    time_t tm;
    cnt_t  pend;
    logic  fin;
  } wake_word_t;

  // Tracks the queue, the clock and the per-consumer wakeup record, and holds
  // the result words still owed by the block.
  class wakeup_scoreboard;
    time_t      slot_tm[QUEUE_DEPTH];
    cid_t       slot_who[QUEUE_DEPTH];
    int         n_slots;
    time_t      now;
    time_t      last_wake[NUM_CONSUMERS];
    wake_word_t due_words[$];
    int         errors;
    int         n_requests;
    int         n_words;
    int         n_woken;
    int         n_full;

    function new();
      n_slots    = 0;
      now        = 1;
      errors     = 0;
      n_requests = 0;
      n_words    = 0;
      n_woken    = 0;
      n_full     = 0;
      foreach (last_wake[i]) last_wake[i] = '0;
    endfunction

    function void push_word(kind_t k, cid_t w, time_t t, logic f);
      wake_word_t wd;
      wd.kind = k;
      wd.who  = w;
      wd.tm   = t;
      wd.pend = cnt_t'(n_slots);
      wd.fin  = f;
      due_words.push_back(wd);
    endfunction

    // earliest event leaves the queue as a wakeup word
    function void pop_due();
      time_t t;
      cid_t  w;
      t = slot_tm[0];
      w = slot_who[0];
      for (int i = 1; i < n_slots; i++) begin
        slot_tm[i-1]  = slot_tm[i];
        slot_who[i-1] = slot_who[i];
      end
      n_slots--;
      now = t;
      n_woken++;
      push_word(KIND_WAKE, w, t, 1'b0);
    endfunction

    function void note_request(logic [1:0] op, cid_t cid, time_t tv);
      kind_t k;
      int    pos;
      n_requests++;
      case (op)
        OP_SCHED: begin
          if (last_wake[cid] == tv) begin
            k = KIND_REDUNDANT;
          end else if (!(tv > now)) begin
            k = KIND_NOT_FUTURE;
          end else if (n_slots >= QUEUE_DEPTH) begin
            k = KIND_FULL;
            n_full++;
          end else begin
            // stable insert: after every event of equal or earlier time
            pos = 0;
            while (pos < n_slots && slot_tm[pos] <= tv) pos++;
            for (int i = n_slots; i > pos; i--) begin
              slot_tm[i]  = slot_tm[i-1];
              slot_who[i] = slot_who[i-1];
            end
            slot_tm[pos]  = tv;
            slot_who[pos] = cid;
            n_slots++;
            last_wake[cid] = tv;
            k = KIND_SCHED;
          end
          push_word(k, cid, tv, 1'b1);
        end
        OP_ADVANCE: begin
          while (n_slots > 0 && slot_tm[0] <= tv) pop_due();
          now = tv;
          push_word(KIND_DONE, '0, now, 1'b1);
        end
        OP_DRAIN: begin
          while (n_slots > 0) pop_due();
          push_word(KIND_DONE, '0, now, 1'b1);
        end
        default: n_requests--;
      endcase
    endfunction

    function void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(logic [2:0] k, cid_t w, time_t t, cnt_t p, logic f);
      wake_word_t exp_w;
      n_words++;
      if (due_words.size() == 0) begin
        $error("unexpected result word: kind %0d consumer %0d time %0d", k, w, t);
        errors++;
        return;
      end
      exp_w = due_words.pop_front();
      check_field("kind", exp_w.kind, k);
      check_field("woken_consumer", exp_w.who, w);
      check_field("event_time", exp_w.tm, t);
      check_field("pending_count", exp_w.pend, p);
      check_field("last", exp_w.fin, f);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet_tail;
  int   cycle_count;

  twq_in_if  in_ch();
  twq_out_if out_ch();

  wakeup_scoreboard wake_model;

  timed_wakeup_event_queue i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed_wakeup_event_queue test failed");
      $finish;
    end
  end

  // result side: random stalls, none in the tail
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      wake_model.check_word(out_ch.kind, out_ch.woken_consumer, out_ch.event_time,
                            out_ch.pending_count, out_ch.last);
  end

  task automatic send_request(logic [1:0] op, cid_t cid, time_t tv);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.consumer_id <= cid;
    in_ch.time_value  <= tv;
    do @(posedge clk); while (!in_ch.ready);
    wake_model.note_request(op, cid, tv);
  endtask

  function automatic time_t future_time(int span);
    return wake_model.now + time_t'($urandom_range(1, span));
  endfunction

  initial begin
    int   n_items;
    int   pick;
    cid_t cid;

    wake_model        = new();
    quiet_tail        = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_SCHED;
    in_ch.consumer_id <= '0;
    in_ch.time_value  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    send_request(OP_SCHED, 6'd0, 32'd0);            // time zero, never scheduled: redundant
    send_request(OP_SCHED, 6'd1, 32'd1);            // not after current time
    send_request(OP_ADVANCE, 6'd0, 32'd0);          // advance into the past, empty queue
    send_request(OP_SCHED, 6'd1, 32'd1);
    send_request(OP_SCHED, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_SCHED, 6'd63, 32'hFFFF_FFFF);   // same time again: redundant
    send_request(OP_SCHED, 6'd2, 32'd1);            // equal time, leaves after consumer 1
    send_request(OP_SCHED, 6'd3, 32'd5);
    send_request(OP_ADVANCE, 6'd0, 32'd1);
    send_request(OP_ADVANCE, 6'd0, 32'd3);          // nothing due
    send_request(OP_UNUSED, 6'h2A, 32'h5A5A_A5A5);
    send_request(OP_SCHED, 6'd3, 32'd2);            // in the past
    send_request(OP_DRAIN, 6'd0, 32'd0);
    send_request(OP_DRAIN, 6'd0, 32'd0);            // empty drain
    send_request(OP_SCHED, 6'd63, 32'hFFFF_FFFF);   // redundant beats not-future
    send_request(OP_SCHED, 6'd4, 32'hFFFF_FFFF);
    send_request(OP_ADVANCE, 6'd0, 32'hFFFF_FFFF);
    send_request(OP_ADVANCE, 6'd0, 32'd16);
    send_request(OP_SCHED, 6'd5, 32'hAAAA_5555);
    send_request(OP_SCHED, 6'd6, 32'h5555_AAAA);
    send_request(OP_ADVANCE, 6'd0, 32'hAAAA_5555);
    send_request(OP_ADVANCE, 6'd0, 32'd16);

    // random part; bursts of schedules push the queue to full
    n_items = 0;
    while (n_items < N_RANDOM) begin
      if (n_items >= N_RANDOM - 40)
        quiet_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (n_items == 0 || pick < 3) begin
        repeat ($urandom_range(30, 36)) begin
          send_request(OP_SCHED, cid_t'($urandom_range(0, NUM_CONSUMERS - 1)),
                       future_time(2000));
          n_items++;
        end
      end else if (pick < 58) begin
        cid = cid_t'($urandom_range(0, NUM_CONSUMERS - 1));
        case ($urandom_range(0, 19))
          0, 1:    send_request(OP_SCHED, cid, time_t'($urandom()));
          2:       send_request(OP_SCHED, cid, wake_model.last_wake[cid]);
          3:       send_request(OP_SCHED, cid, time_t'($urandom_range(0, wake_model.now)));
          default: send_request(OP_SCHED, cid, future_time(400));
        endcase
        n_items++;
      end else if (pick < 88) begin
        case ($urandom_range(0, 9))
          0:       send_request(OP_ADVANCE, cid_t'($urandom()), time_t'($urandom()));
          1:       send_request(OP_ADVANCE, 6'd0, time_t'($urandom_range(0, 64)));
          default: send_request(OP_ADVANCE, cid_t'($urandom()),
                                wake_model.now + time_t'($urandom_range(0, 500)));
        endcase
        n_items++;
      end else if (pick < 96) begin
        send_request(OP_DRAIN, cid_t'($urandom()), time_t'($urandom()));
        n_items++;
      end else begin
        send_request(OP_UNUSED, cid_t'($urandom()), time_t'($urandom()));
      end
    end
    in_ch.valid <= 1'b0;

    while (wake_model.due_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d requests sent, %0d result words checked", wake_model.n_requests,
             wake_model.n_words);
    $display("%0d wakeups, %0d full-queue rejects seen", wake_model.n_woken,
             wake_model.n_full);
    if (wake_model.errors == 0) begin
      $display("timed_wakeup_event_queue test passed");
    end else begin
      $display("timed_wakeup_event_queue test failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/twq_pkg.sv
design/twq_if.sv
design/twq_ram.sv
design/twq_cell.sv
design/timed_wakeup_event_queue.sv
tb/sv/tb_timed_wakeup_event_queue.sv
